@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Both expect clk in scope; SCP_ASSERT also needs rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SCP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/scp_pkg.sv @@
package scp_pkg;

    // Q.48 angle constants
    localparam logic [55:0] PiQ48          = 56'h3243F6A8885A3;
    localparam logic [55:0] TwoPiQ48       = 56'h6487ED5110B46;
    localparam logic [55:0] HalfPiQ48      = 56'h1921FB54442D2;
    localparam logic [55:0] ThreeHalfPiQ48 = PiQ48 + HalfPiQ48;

    // Number of conditional subtract stages in the 2*pi reduction
    localparam int RedSteps = 5;
    // Horner steps after the leading coefficient
    localparam int HornerSteps = 6;

    localparam logic [127:0] Scale17 = 128'd100000000000000000;
    localparam logic [127:0] Scale18 = 128'd1000000000000000000;
    localparam logic [127:0] Scale19 = 128'd10000000000000000000;

    // Minimax cosine coefficients, signed Q.60, rounded to nearest
    localparam logic signed [63:0] Coef0 =
        64'(((128'd99999999999925182 << 60) + Scale17 / 2) / Scale17);
    localparam logic signed [63:0] Coef1 =
        -64'(((128'd49999999997024012 << 60) + Scale17 / 2) / Scale17);
    localparam logic signed [63:0] Coef2 =
        64'(((128'd41666666473384543 << 60) + Scale18 / 2) / Scale18);
    localparam logic signed [63:0] Coef3 =
        -64'(((128'd1388888418000423 << 60) + Scale18 / 2) / Scale18);
    localparam logic signed [63:0] Coef4 =
        64'(((128'd248010406484558 << 60) + Scale19 / 2) / Scale19);
    localparam logic signed [63:0] Coef5 =
        -64'(((128'd2752469638432 << 60) + Scale19 / 2) / Scale19);
    localparam logic signed [63:0] Coef6 =
        64'(((128'd19907856854 << 60) + Scale19 / 2) / Scale19);

    localparam logic signed [63:0] HornerCoef [HornerSteps] =
        '{Coef0, Coef1, Coef2, Coef3, Coef4, Coef5};

    // Half an LSB for the Q.60 product rounding
    localparam logic [62:0] RoundQ60 = 63'd1 << 59;
    // Half an LSB and full scale for the Q2.30 output
    localparam logic [64:0] OutHalf  = 65'd1 << 29;
    localparam logic [31:0] OutOne   = 32'd1 << 30;

    typedef struct packed {
        logic        flip;
        logic [61:0] x2;
    } scp_side_t;

    typedef struct packed {
        logic               vld;
        logic               flip;
        logic signed [63:0] acc;
        logic [61:0]        x2;
    } scp_step_t;

endpackage

@@ hw/rtl/scp_in_if.sv @@
interface scp_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] angle;

    modport source (output valid, output action, output angle, input ready);
    modport sink (input valid, input action, input angle, output ready);
endinterface

@@ hw/rtl/scp_out_if.sv @@
interface scp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

@@ hw/rtl/scp_horner_step.sv @@
// One step acc_out = coef + round(acc * x2 / 2^60), five register stages.
// The 62x62 product is built from four 31x31 partial products.
module scp_horner_step
    import scp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic signed [63:0] coef,
    input  scp_step_t          din,
    output scp_step_t          dout
);

    // stage 1: sign and magnitude
    logic        s1_vld_reg;
    logic        s1_neg_reg;
    logic [61:0] s1_mag_reg;
    scp_side_t   s1_side_reg;
    logic [63:0] s1_mag_next;

    // stage 2: partial products
    logic        s2_vld_reg;
    logic        s2_neg_reg;
    scp_side_t   s2_side_reg;
    logic [61:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [61:0] p00_next, p01_next, p10_next, p11_next;
    logic [30:0] a_lo, a_hi, b_lo, b_hi;

    // stage 3: cross terms and rounding bias
    logic        s3_vld_reg;
    logic        s3_neg_reg;
    scp_side_t   s3_side_reg;
    logic [62:0] s3_mid_reg, s3_low_reg;
    logic [61:0] s3_p11_reg;
    logic [62:0] s3_mid_next, s3_low_next;

    // stage 4: full sum, take bits 123:60
    logic        s4_vld_reg;
    logic        s4_neg_reg;
    scp_side_t   s4_side_reg;
    logic [63:0] s4_m_reg;
    logic [123:0] s4_total_next;

    // stage 5: add coefficient
    logic               s5_vld_reg;
    scp_side_t          s5_side_reg;
    logic signed [63:0] s5_acc_reg;
    logic [63:0]        s5_term_next;
    logic signed [63:0] s5_acc_next;

    assign s1_mag_next = din.acc[63] ? (~din.acc + 64'd1) : din.acc;

    assign a_lo = s1_mag_reg[30:0];
    assign a_hi = s1_mag_reg[61:31];
    assign b_lo = s1_side_reg.x2[30:0];
    assign b_hi = s1_side_reg.x2[61:31];
    assign p00_next = 62'(a_lo) * 62'(b_lo);
    assign p01_next = 62'(a_lo) * 62'(b_hi);
    assign p10_next = 62'(a_hi) * 62'(b_lo);
    assign p11_next = 62'(a_hi) * 62'(b_hi);

    assign s3_mid_next = {1'b0, p01_reg} + {1'b0, p10_reg};
    assign s3_low_next = {1'b0, p00_reg} + RoundQ60;

    assign s4_total_next = {s3_p11_reg, 62'b0} + {30'b0, s3_mid_reg, 31'b0}
                         + {61'b0, s3_low_reg};

    assign s5_term_next = s4_neg_reg ? (~s4_m_reg + 64'd1) : s4_m_reg;
    assign s5_acc_next  = coef + $signed(s5_term_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= din.vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_neg_reg       <= din.acc[63];
            s1_mag_reg       <= s1_mag_next[61:0];
            s1_side_reg.flip <= din.flip;
            s1_side_reg.x2   <= din.x2;

            s2_neg_reg  <= s1_neg_reg;
            s2_side_reg <= s1_side_reg;
            p00_reg     <= p00_next;
            p01_reg     <= p01_next;
            p10_reg     <= p10_next;
            p11_reg     <= p11_next;

            s3_neg_reg  <= s2_neg_reg;
            s3_side_reg <= s2_side_reg;
            s3_mid_reg  <= s3_mid_next;
            s3_low_reg  <= s3_low_next;
            s3_p11_reg  <= p11_reg;

            s4_neg_reg  <= s3_neg_reg;
            s4_side_reg <= s3_side_reg;
            s4_m_reg    <= s4_total_next[123:60];

            s5_side_reg <= s4_side_reg;
            s5_acc_reg  <= s5_acc_next;
        end
    end

    assign dout.vld  = s5_vld_reg;
    assign dout.flip = s5_side_reg.flip;
    assign dout.acc  = s5_acc_reg;
    assign dout.x2   = s5_side_reg.x2;

endmodule

@@ hw/rtl/sine_cosine_polynomial_unit.sv @@
// Fixed-point cosine / sine unit.
// operand channel: action (0 = cosine, 1 = sine) and angle in radians, Q8.24.
// result channel: value in Q2.30, saturated to +/-1.0, one beat per operand beat.
// Both channels use valid/ready; a beat moves when both are high.
// Flow: angle -> Q.48, sine offset, magnitude, five-stage reduction modulo
// 2*pi, quadrant fold, squaring, six Horner steps (five stages each), output
// rounding and clamp: 47 register stages in all. One operand is accepted per
// cycle while the skid register is empty, and results leave in operand order.
// The depth is set by the seven 62x62-bit multiplies, each split into four
// 31x31 products over five stages.
// A skid register follows the output stage. When the receiver stalls, the
// stalled result moves into it while the pipeline still advances; while it
// is full, operand.ready is low and the pipeline holds. Nothing is dropped or
// repeated. Reset clears all valid bits; no result is pending after reset.
`include "assert_macros.svh"

module sine_cosine_polynomial_unit
    import scp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    scp_in_if.sink    operand,
    scp_out_if.source result
);

    logic en;

    // front: Q.48 angle with sine offset
    logic               a_vld_reg;
    logic signed [56:0] a_x_reg;
    logic signed [56:0] ang_q48;
    logic signed [56:0] a_x_next;
    logic [56:0]        b_abs_next;

    // reduction: index 0 is the magnitude stage
    logic        red_vld_reg [RedSteps + 1];
    logic [55:0] red_mag_reg [RedSteps + 1];

    // quadrant fold
    logic        q1_vld_reg;
    logic [55:0] q1_mag_reg;
    logic        q1_lt_half_reg, q1_lt_pi_reg, q1_lt_3half_reg;
    logic        q2_vld_reg;
    logic        q2_flip_reg;
    logic [48:0] q2_arg_reg;
    logic [55:0] q2_arg_next;

    // polynomial
    scp_step_t sq_in, sq_out;
    scp_step_t hs_in  [HornerSteps];
    scp_step_t hs_out [HornerSteps];

    // output rounding
    logic        e1_vld_reg, e1_flip_reg;
    logic [63:0] e1_mag_reg;
    logic [63:0] e1_mag_next;
    logic        e2_vld_reg, e2_flip_reg;
    logic [34:0] e2_mag_reg;
    logic [64:0] e2_rnd_next;
    logic        out_vld_reg;
    logic [31:0] out_value_reg;
    logic [30:0] out_clamp_next;
    logic [31:0] out_value_next;

    logic        skid_vld_reg;
    logic [31:0] skid_value_reg;

    assign en            = !skid_vld_reg;
    assign operand.ready = en;

    assign ang_q48  = {operand.angle[31], operand.angle, 24'b0};
    assign a_x_next = operand.action ? ($signed({1'b0, HalfPiQ48}) - ang_q48) : ang_q48;
    assign b_abs_next = a_x_reg[56] ? (~a_x_reg + 57'd1) : a_x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg      <= 1'b0;
            red_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg      <= operand.valid;
            red_vld_reg[0] <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x_reg        <= a_x_next;
            red_mag_reg[0] <= b_abs_next[55:0];
        end
    end

    // restoring reduction: subtract 2*pi * 16, 8, 4, 2, 1
    for (genvar s = 1; s <= RedSteps; s++)
    begin : g_red
        logic [55:0] sub_c;
        logic [55:0] mag_next;

        assign sub_c    = TwoPiQ48 << (RedSteps - s);
        assign mag_next = (red_mag_reg[s-1] >= sub_c) ? (red_mag_reg[s-1] - sub_c)
                                                      : red_mag_reg[s-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                red_vld_reg[s] <= 1'b0;
            else if (en)
                red_vld_reg[s] <= red_vld_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                red_mag_reg[s] <= mag_next;
        end
    end

    always_comb
    begin
        if (q1_lt_half_reg)
            q2_arg_next = q1_mag_reg;
        else if (q1_lt_pi_reg)
            q2_arg_next = PiQ48 - q1_mag_reg;
        else if (q1_lt_3half_reg)
            q2_arg_next = q1_mag_reg - PiQ48;
        else
            q2_arg_next = TwoPiQ48 - q1_mag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_vld_reg <= 1'b0;
            q2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            q1_vld_reg <= red_vld_reg[RedSteps];
            q2_vld_reg <= q1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_mag_reg      <= red_mag_reg[RedSteps];
            q1_lt_half_reg  <= red_mag_reg[RedSteps] < HalfPiQ48;
            q1_lt_pi_reg    <= red_mag_reg[RedSteps] < PiQ48;
            q1_lt_3half_reg <= red_mag_reg[RedSteps] < ThreeHalfPiQ48;
            // second and third quadrants negate
            q2_flip_reg     <= q1_lt_3half_reg && !q1_lt_half_reg;
            q2_arg_reg      <= q2_arg_next[48:0];
        end
    end

    // x squared, Q.60
    assign sq_in.vld  = q2_vld_reg;
    assign sq_in.flip = q2_flip_reg;
    assign sq_in.acc  = $signed({3'b0, q2_arg_reg, 12'b0});
    assign sq_in.x2   = {1'b0, q2_arg_reg, 12'b0};

    scp_horner_step u_square (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .coef  (64'sd0),
        .din   (sq_in),
        .dout  (sq_out)
    );

    assign hs_in[0].vld  = sq_out.vld;
    assign hs_in[0].flip = sq_out.flip;
    assign hs_in[0].acc  = Coef6;
    assign hs_in[0].x2   = sq_out.acc[61:0];

    for (genvar i = 0; i < HornerSteps; i++)
    begin : g_horner
        if (i > 0)
        begin : g_link
            assign hs_in[i] = hs_out[i-1];
        end

        scp_horner_step u_step (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .coef  (HornerCoef[HornerSteps - 1 - i]),
            .din   (hs_in[i]),
            .dout  (hs_out[i])
        );
    end

    // a slightly negative polynomial keeps its sign under the quadrant flip
    assign e1_mag_next = hs_out[HornerSteps-1].acc[63]
                       ? (~hs_out[HornerSteps-1].acc + 64'd1)
                       : hs_out[HornerSteps-1].acc;
    assign e2_rnd_next = {1'b0, e1_mag_reg} + OutHalf;
    assign out_clamp_next = (e2_mag_reg > {3'b0, OutOne}) ? OutOne[30:0] : e2_mag_reg[30:0];
    assign out_value_next = e2_flip_reg ? (~{1'b0, out_clamp_next} + 32'd1)
                                        : {1'b0, out_clamp_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_vld_reg  <= 1'b0;
            e2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e1_vld_reg  <= hs_out[HornerSteps-1].vld;
            e2_vld_reg  <= e1_vld_reg;
            out_vld_reg <= e2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_flip_reg   <= hs_out[HornerSteps-1].flip ^ hs_out[HornerSteps-1].acc[63];
            e1_mag_reg    <= e1_mag_next;
            e2_flip_reg   <= e1_flip_reg;
            e2_mag_reg    <= e2_rnd_next[64:30];
            out_value_reg <= out_value_next;
        end
    end

    // skid: catches the output beat when the pipeline moves under a stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_vld_reg <= 1'b0;
        else if (skid_vld_reg)
        begin
            if (result.ready)
                skid_vld_reg <= 1'b0;
        end
        else if (out_vld_reg && !result.ready)
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!skid_vld_reg)
            skid_value_reg <= out_value_reg;
    end

    assign result.valid = skid_vld_reg || out_vld_reg;
    assign result.value = skid_vld_reg ? skid_value_reg : out_value_reg;

    `SCP_ASSERT(a_value_range, result.valid |-> ($signed(result.value) <= $signed(OutOne) && $signed(result.value) >= -$signed(OutOne)), "result out of +/-1.0")
    `SCP_ASSERT(a_skid_fill, $rose(skid_vld_reg) |-> $past(out_vld_reg && !result.ready), "skid filled without a stalled beat")
    `SCP_ASSERT(a_skid_hold, skid_vld_reg |=> ($stable(out_vld_reg) && $stable(out_value_reg)), "pipeline moved while skid full")
    `SCP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !result.valid, "result valid during reset")

endmodule
